// ===== sv/pbfd_pkg.sv =====
`timescale 1ns / 1ps

package pbfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIM_W     = 13;
    localparam int OFS_W     = 26;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // decoder phases
    localparam logic [1:0] PH_MARKER  = 2'd0;
    localparam logic [1:0] PH_COUNT   = 2'd1;
    localparam logic [1:0] PH_RUN     = 2'd2;
    localparam logic [1:0] PH_LITERAL = 2'd3;

    localparam logic [BYTE_W-1:0] END_MARK = 8'h45;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [OFS_W-1:0]  t_ofs;
    typedef logic [BYTE_W-1:0] t_byte;

    // one decoded result beat
    typedef struct packed {
        t_byte pixel_value;
        t_byte repeat_count;
        t_ofs  start_offset;
        logic  frame_end;
        logic  overrun;
    } t_result;

endpackage

// ===== sv/pbfd_cfg.sv =====
`timescale 1ns / 1ps

module pbfd_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [pbfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbfd_pkg::DIM_W-1:0]      i_cfg_data,
    output pbfd_pkg::t_ofs                  o_frame_total
);

    pbfd_pkg::t_dim r_width;
    pbfd_pkg::t_dim r_height;
    pbfd_pkg::t_ofs r_dim_prod;
    pbfd_pkg::t_dim w_clamped;
    pbfd_pkg::t_dim h_clamped;
    logic [pbfd_pkg::OFS_W+1:0] w_times3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pbfd_pkg::DIM_W'(1);
            r_height <= pbfd_pkg::DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pbfd_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                pbfd_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // zero counts as one, oversize clamps to the maximum
    always_comb begin
        if (r_width == '0) begin
            w_clamped = pbfd_pkg::DIM_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_clamped = pbfd_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            w_clamped = r_width;
        end
        if (r_height == '0) begin
            h_clamped = pbfd_pkg::DIM_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_clamped = pbfd_pkg::DIM_W'(MAX_HEIGHT);
        end else begin
            h_clamped = r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_prod <= pbfd_pkg::OFS_W'(1);
        end else begin
            r_dim_prod <= pbfd_pkg::OFS_W'(w_clamped) * pbfd_pkg::OFS_W'(h_clamped);
        end
    end

    // three channel planes, saturate at the offset range
    assign w_times3 = {2'b00, r_dim_prod} + {1'b0, r_dim_prod, 1'b0};
    assign o_frame_total = (w_times3[pbfd_pkg::OFS_W+1:pbfd_pkg::OFS_W] != 2'b00)
                         ? '1 : w_times3[pbfd_pkg::OFS_W-1:0];

endmodule

// ===== sv/pbfd_decode.sv =====
`timescale 1ns / 1ps

module pbfd_decode #(
    parameter int MIN_RUN = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  pbfd_pkg::t_byte        i_stream_byte,
    input  pbfd_pkg::t_ofs         i_frame_total,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pbfd_pkg::t_result      o_result
);

    logic              r_in_valid;
    pbfd_pkg::t_byte   r_in_byte;
    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    pbfd_pkg::t_byte   r_pending;
    pbfd_pkg::t_byte   n_pending;
    pbfd_pkg::t_ofs    r_values_done;
    pbfd_pkg::t_ofs    n_values_done;
    pbfd_pkg::t_ofs    r_remaining;
    pbfd_pkg::t_ofs    n_remaining;
    logic              r_out_valid;
    pbfd_pkg::t_result r_out;
    pbfd_pkg::t_result n_out;
    logic              n_emit;
    logic              w_out_free;
    logic              w_fire;
    logic              w_in_accept;
    pbfd_pkg::t_byte   w_rep;
    pbfd_pkg::t_byte   w_left;
    logic              w_clip;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_stream_byte;
        end
    end

    assign w_clip = pbfd_pkg::OFS_W'(r_pending) > r_remaining;
    assign w_rep  = w_clip ? r_remaining[pbfd_pkg::BYTE_W-1:0] : r_pending;
    assign w_left = (r_pending != '0) ? r_pending - 8'd1 : 8'd0;

    always_comb begin
        n_phase       = r_phase;
        n_pending     = r_pending;
        n_values_done = r_values_done;
        n_remaining   = r_remaining;
        n_emit        = 1'b0;
        n_out.pixel_value  = r_in_byte;
        n_out.repeat_count = 8'd1;
        n_out.start_offset = r_values_done;
        n_out.frame_end    = 1'b0;
        n_out.overrun      = 1'b0;
        unique case (r_phase)
            pbfd_pkg::PH_MARKER: begin
                if (r_in_byte != pbfd_pkg::END_MARK) begin
                    n_remaining   = i_frame_total;
                    n_values_done = '0;
                    n_pending     = '0;
                    n_phase       = pbfd_pkg::PH_COUNT;
                end
            end
            pbfd_pkg::PH_COUNT: begin
                if (r_in_byte[pbfd_pkg::BYTE_W-1]) begin
                    n_pending = 8'(MIN_RUN - 1) + (8'd0 - r_in_byte);
                    n_phase   = pbfd_pkg::PH_RUN;
                end else begin
                    n_pending = r_in_byte + 8'd1;
                    n_phase   = pbfd_pkg::PH_LITERAL;
                end
            end
            pbfd_pkg::PH_RUN: begin
                n_pending = '0;
                if (r_remaining == '0) begin
                    n_phase = pbfd_pkg::PH_MARKER;
                end else begin
                    n_emit             = 1'b1;
                    n_out.repeat_count = w_rep;
                    n_out.overrun      = w_clip;
                    n_out.frame_end    = pbfd_pkg::OFS_W'(w_rep) == r_remaining;
                    n_values_done      = r_values_done + pbfd_pkg::OFS_W'(w_rep);
                    n_remaining        = r_remaining - pbfd_pkg::OFS_W'(w_rep);
                    n_phase = n_out.frame_end ? pbfd_pkg::PH_MARKER : pbfd_pkg::PH_COUNT;
                end
            end
            pbfd_pkg::PH_LITERAL: begin
                n_pending = w_left;
                if (r_remaining == '0) begin
                    // past frame end: consume the rest of the block silently
                    if (w_left == '0) begin
                        n_phase = pbfd_pkg::PH_MARKER;
                    end
                end else begin
                    n_emit          = 1'b1;
                    n_out.frame_end = r_remaining == pbfd_pkg::OFS_W'(1);
                    n_out.overrun   = n_out.frame_end && (w_left != '0);
                    n_values_done   = r_values_done + pbfd_pkg::OFS_W'(1);
                    n_remaining     = r_remaining - pbfd_pkg::OFS_W'(1);
                    if (w_left == '0) begin
                        n_phase = n_out.frame_end ? pbfd_pkg::PH_MARKER
                                                  : pbfd_pkg::PH_COUNT;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pbfd_pkg::PH_MARKER;
            r_pending     <= '0;
            r_values_done <= '0;
            r_remaining   <= pbfd_pkg::OFS_W'(3);
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_pending     <= n_pending;
            r_values_done <= n_values_done;
            r_remaining   <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== sv/packbits_frame_decoder_top.sv =====
`timescale 1ns / 1ps

// PackBits frame decoder.
//
// Input channel: one compressed byte per beat on i_stream_byte, qualified by
// i_in_valid and held off by o_in_stall. Between frames a marker byte opens
// a frame of width * height * 3 channel values ('E' is skipped). Inside a
// frame, count bytes select a repeated value or a block of literal bytes.
// Output channel: one beat per decoded value, carrying the value, how many
// positions it fills, its frame offset, and frame-end / overrun flags.
// Count and marker bytes produce no output beat.
// Configuration: frame_width (index 0) and frame_height (index 1) are written
// over i_cfg_valid / i_cfg_index / i_cfg_data; o_cfg_ready is always high.
// A new size takes effect when the next frame opens.
// Pipeline: an accepted byte is held in the input register, and its result
// is then written to the result register. Throughput: one byte per cycle
// while the receiver does not stall; a single input register and a single
// result register bound the pipeline.
// Stall: while i_out_stall holds a result, the next byte still enters the
// input register; further bytes are stalled until the result is taken.
// Reset (synchronous, active low): waits for a marker, size 1 x 1, no beats.

module packbits_frame_decoder_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MIN_RUN    = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_stream_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_pixel_value,
    output logic [7:0]                      o_repeat_count,
    output logic [25:0]                     o_start_offset,
    output logic                            o_frame_end,
    output logic                            o_overrun,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pbfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [12:0]                     i_cfg_data
);

    pbfd_pkg::t_ofs    w_frame_total;
    pbfd_pkg::t_result w_result;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    pbfd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_frame_total (w_frame_total)
    );

    pbfd_decode #(
        .MIN_RUN (MIN_RUN)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .i_frame_total (w_frame_total),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (w_result)
    );

    // unpack the result beat onto its ports
    assign o_pixel_value  = w_result.pixel_value;
    assign o_repeat_count = w_result.repeat_count;
    assign o_start_offset = w_result.start_offset;
    assign o_frame_end    = w_result.frame_end;
    assign o_overrun      = w_result.overrun;

`ifndef SYNTHESIS
    // a clipped run or literal always ends the frame
    a_overrun_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overrun |-> o_frame_end)
        else $error("overrun beat without frame end");

    // every result beat fills at least one position
    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_repeat_count != 8'd0)
        else $error("result beat with zero repeat count");

    // reset clears the result valid flag
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_W          = 4096;
    localparam int MAX_H          = 4096;
    localparam int RUN_MIN        = 3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // indexes that map to no register
    localparam logic [pbfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [pbfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [pbfd_pkg::OFS_W-1:0] OFS_MAX = '1;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_stall;
    logic [7:0]                     i_stream_byte = 8'h00;
    logic                           o_out_valid;
    logic                           i_out_stall   = 1'b0;
    logic [7:0]                     o_pixel_value;
    logic [7:0]                     o_repeat_count;
    logic [25:0]                    o_start_offset;
    logic                           o_frame_end;
    logic                           o_overrun;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [pbfd_pkg::CFG_IDX_W-1:0] i_cfg_index   = pbfd_pkg::CFG_FRAME_WIDTH;
    logic [12:0]                    i_cfg_data    = 13'd0;

    packbits_frame_decoder_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .MIN_RUN    (RUN_MIN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stream_byte  (i_stream_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_count (o_repeat_count),
        .o_start_offset (o_start_offset),
        .o_frame_end    (o_frame_end),
        .o_overrun      (o_overrun),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder mirror: register copies and frame state, updated once per
    // accepted input beat.
    // ------------------------------------------------------------------
    pbfd_pkg::t_dim  cfg_width   = 13'd1;
    pbfd_pkg::t_dim  cfg_height  = 13'd1;
    logic [1:0]      dec_phase   = pbfd_pkg::PH_MARKER;
    pbfd_pkg::t_byte dec_pending = '0;
    pbfd_pkg::t_ofs  dec_filled  = '0;
    pbfd_pkg::t_ofs  dec_total   = 26'd3;

    pbfd_pkg::t_result expected_results[$];
    pbfd_pkg::t_result want;

    int         error_count   = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int unsigned quiet_cycles = 0;

    // Clamp each dimension, then saturate width * height * 3 at the offset width.
    function automatic pbfd_pkg::t_ofs frame_size(input pbfd_pkg::t_dim w,
                                                  input pbfd_pkg::t_dim h);
        longint unsigned wc;
        longint unsigned hc;
        longint unsigned prod;
        wc = (w == 0) ? 64'd1 : ((w > MAX_W) ? 64'(MAX_W) : 64'(w));
        hc = (h == 0) ? 64'd1 : ((h > MAX_H) ? 64'(MAX_H) : 64'(h));
        prod = wc * hc * 64'd3;
        if (prod > 64'(OFS_MAX))
            prod = 64'(OFS_MAX);
        return prod[pbfd_pkg::OFS_W-1:0];
    endfunction

    // Advance the mirror by one stream byte; queue the beat it produces, if any.
    task automatic decode_byte(input pbfd_pkg::t_byte b);
        pbfd_pkg::t_ofs    room;
        pbfd_pkg::t_byte   reps;
        pbfd_pkg::t_byte   left;
        pbfd_pkg::t_result r;
        r    = '0;
        room = (dec_total > dec_filled) ? dec_total - dec_filled : '0;
        case (dec_phase)
            pbfd_pkg::PH_MARKER: begin
                if (b != pbfd_pkg::END_MARK) begin
                    dec_total   = frame_size(cfg_width, cfg_height);
                    dec_filled  = '0;
                    dec_pending = '0;
                    dec_phase   = pbfd_pkg::PH_COUNT;
                end
            end
            pbfd_pkg::PH_COUNT: begin
                if (b[7]) begin
                    dec_pending = pbfd_pkg::t_byte'(RUN_MIN - 1 + 256 - int'(b));
                    dec_phase   = pbfd_pkg::PH_RUN;
                end else begin
                    dec_pending = b + 8'd1;
                    dec_phase   = pbfd_pkg::PH_LITERAL;
                end
            end
            pbfd_pkg::PH_RUN: begin
                reps        = dec_pending;
                dec_pending = '0;
                if (room == 0) begin
                    dec_phase = pbfd_pkg::PH_MARKER;
                end else begin
                    r.pixel_value  = b;
                    r.start_offset = dec_filled;
                    // clip the run to what the frame still holds
                    if (pbfd_pkg::t_ofs'(reps) > room) begin
                        reps      = room[pbfd_pkg::BYTE_W-1:0];
                        r.overrun = 1'b1;
                    end
                    r.repeat_count = reps;
                    r.frame_end    = (pbfd_pkg::t_ofs'(reps) == room);
                    dec_filled     = dec_filled + pbfd_pkg::t_ofs'(reps);
                    dec_phase      = r.frame_end ? pbfd_pkg::PH_MARKER : pbfd_pkg::PH_COUNT;
                    expected_results.push_back(r);
                end
            end
            pbfd_pkg::PH_LITERAL: begin
                left        = (dec_pending > 0) ? dec_pending - 8'd1 : 8'd0;
                dec_pending = left;
                if (room == 0) begin
                    // frame already full: swallow the rest of the literal block
                    if (left == 0)
                        dec_phase = pbfd_pkg::PH_MARKER;
                end else begin
                    r.pixel_value  = b;
                    r.repeat_count = 8'd1;
                    r.start_offset = dec_filled;
                    r.frame_end    = (room == 1);
                    r.overrun      = r.frame_end && (left != 0);
                    dec_filled     = dec_filled + pbfd_pkg::t_ofs'(1);
                    if (left == 0)
                        dec_phase = r.frame_end ? pbfd_pkg::PH_MARKER : pbfd_pkg::PH_COUNT;
                    expected_results.push_back(r);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input beats: idle at random, then hold the byte until accepted.
    // Valid stays high into the next call when no gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_byte(input pbfd_pkg::t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (!(dec_phase == pbfd_pkg::PH_MARKER && b == pbfd_pkg::END_MARK))
            items_sent++;
        decode_byte(b);
    endtask

    // Drop valid, wait until every queued beat has arrived, then let the
    // pipeline settle: a trailing count or marker byte leaves no beat behind.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pbfd_pkg::CFG_IDX_W-1:0] idx,
                             input pbfd_pkg::t_dim val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pbfd_pkg::CFG_FRAME_WIDTH:  cfg_width  = val;
            pbfd_pkg::CFG_FRAME_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic set_size(input pbfd_pkg::t_dim w, input pbfd_pkg::t_dim h);
        cfg_write(pbfd_pkg::CFG_FRAME_WIDTH, w);
        cfg_write(pbfd_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // Mostly short runs and short literal blocks; now and then any count,
    // which lets long runs and literal blocks overrun small frames.
    function automatic pbfd_pkg::t_byte pick_count();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return pbfd_pkg::t_byte'($urandom_range(255, 248));
        if (sel < 80)
            return pbfd_pkg::t_byte'($urandom_range(3, 0));
        return pbfd_pkg::t_byte'($urandom);
    endfunction

    function automatic pbfd_pkg::t_dim rand_dim();
        if ($urandom_range(99) < 10)
            return '0;
        return pbfd_pkg::t_dim'($urandom_range(4, 1));
    endfunction

    // Feed count and value bytes until the mirror is back at the marker wait.
    task automatic finish_frame(input bit long_runs);
        while (dec_phase != pbfd_pkg::PH_MARKER) begin
            if (dec_phase == pbfd_pkg::PH_COUNT)
                send_byte(long_runs ? 8'h80 : pick_count());
            else
                send_byte(pbfd_pkg::t_byte'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size is 1 x 1: three values. Skip 'E' markers, then fill with
    // a run of exactly three.
    task automatic test_reset_size();
        send_byte(pbfd_pkg::END_MARK);
        send_byte(pbfd_pkg::END_MARK);
        send_byte(8'h46);
        send_byte(8'hFF);
        send_byte(8'hAA);
        // three literals fill the next frame exactly, no overrun
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
    endtask

    // Longest and shortest runs, single literal and the longest literal block.
    task automatic test_run_lengths();
        set_size(13'd100, 13'd1);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h7F);
        repeat (128) send_byte(pbfd_pkg::t_byte'($urandom));
        finish_frame(1'b0);
    endtask

    // Run longer than the frame: clip, flag overrun and frame end together.
    task automatic test_run_overrun();
        set_size(13'd1, 13'd1);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hC3);
    endtask

    // Literal block longer than the frame: the last fitting byte is flagged,
    // the rest is swallowed and the decoder waits for a marker again.
    task automatic test_literal_overrun();
        send_byte(8'h7F);
        send_byte(8'h04);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'h55);
        send_byte(pbfd_pkg::END_MARK);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h99);
    endtask

    // Zero dimensions count as one; oversized ones clamp to the maximum.
    task automatic test_size_clamp();
        set_size(13'd0, 13'd0);
        send_byte(8'h02);
        send_byte(8'h80);
        send_byte(8'h3C);
        set_size(13'h1FFF, 13'd1);
        send_byte(8'h03);
        finish_frame(1'b1);
        set_size(13'd1, 13'h1000);
        send_byte(8'h04);
        finish_frame(1'b1);
    endtask

    // Writes to unmapped indexes must leave the size alone.
    task automatic test_unknown_index();
        set_size(13'd2, 13'd1);
        cfg_write(CFG_SPARE_2, 13'h1FFF);
        cfg_write(CFG_SPARE_3, 13'h0000);
        send_byte(8'h05);
        send_byte(8'hFC);
        send_byte(8'h6E);
        finish_frame(1'b0);
    endtask

    // A size written inside a frame waits for the next marker. The write
    // pauses the sender until all queued beats have arrived.
    task automatic test_config_mid_frame();
        set_size(13'd1, 13'd1);
        send_byte(8'h10);
        send_byte(8'h00);
        send_byte(8'h33);
        set_size(13'd2, 13'd2);
        send_byte(8'hFE);
        send_byte(8'h77);
        send_byte(8'h20);
        finish_frame(1'b0);
    endtask

    // Well-formed frames with random content; random sizes between frames,
    // stray 'E' bytes ahead of markers.
    task automatic test_random_frames(input int budget);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < budget) begin
            if ($urandom_range(99) < 25)
                set_size(rand_dim(), rand_dim());
            if ($urandom_range(99) < 15)
                send_byte(pbfd_pkg::END_MARK);
            send_byte(pbfd_pkg::t_byte'($urandom));
            finish_frame(1'b0);
        end
    endtask

    // Largest frame: open it and decode six runs or literal blocks; it stays open to the end.
    task automatic test_max_frame();
        set_size(13'h1FFF, 13'h1FFF);
        send_byte(8'h81);
        repeat (6) begin
            send_byte(pick_count());
            while (dec_phase != pbfd_pkg::PH_COUNT)
                send_byte(pbfd_pkg::t_byte'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall and result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each taken beat against the oldest queued expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing queued: value %0d offset %0d",
                       o_pixel_value, o_start_offset);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("pixel_value", want.pixel_value, o_pixel_value);
                check_field("repeat_count", want.repeat_count, o_repeat_count);
                check_field("start_offset", want.start_offset, o_start_offset);
                check_field("frame_end", want.frame_end, o_frame_end);
                check_field("overrun", want.overrun, o_overrun);
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_run_lengths();
        test_run_overrun();
        test_literal_overrun();
        test_size_clamp();
        test_unknown_index();
        test_config_mid_frame();

        // no idling
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_frames(30);
        // sender idles
        send_idle_pct = 54;
        stall_pct     = 0;
        test_random_frames(30);
        // receiver stalls
        send_idle_pct = 0;
        stall_pct     = 54;
        test_random_frames(30);
        // both
        send_idle_pct = 26;
        stall_pct     = 26;
        test_random_frames(30);

        test_max_frame();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== packbits_frame_decoder_top.f =====
sv/pbfd_pkg.sv
sv/pbfd_cfg.sv
sv/pbfd_decode.sv
sv/packbits_frame_decoder_top.sv
tb/testbench.sv
